// ----- src/rational_arithmetic_unit_macros.svh -----
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/rau_pkg.sv -----
// Package: operation codes and sequencer states of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

    typedef enum logic [2:0] {
        FUNC_ADD = 3'd0,
        FUNC_SUB = 3'd1,
        FUNC_MUL = 3'd2,
        FUNC_DIV = 3'd3,
        FUNC_CMP = 3'd4,
        FUNC_RED = 3'd5
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_PREP,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

// ----- src/rau_if.sv -----
// Channel interfaces: operand items in, reduced results out.
`timescale 1ns / 1ps
`default_nettype none
interface rau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;

    modport source(output valid, func, a_num, a_den, b_num, b_den, input ready);
    modport sink(input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               status;

    modport source(output valid, res_num, res_den, is_less, is_equal, is_greater, status,
                   input ready);
    modport sink(input valid, res_num, res_den, is_less, is_equal, is_greater, status,
                 output ready);
endinterface
`default_nettype wire

// ----- src/rau_mul.sv -----
// Shift-add multiplier, low WIDTH bits of the product, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rau_mul #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_p
);
    logic             r_busy;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_b == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && r_b != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    // stops early once the remaining multiplier bits are all zero
    assign o_done = r_busy && (r_b == '0);
    assign o_p    = r_acc;
endmodule
`default_nettype wire

// ----- src/rau_gcd.sv -----
// Binary gcd of two nonzero unsigned values, one shift or subtract per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rau_gcd #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_u,
    input  wire logic [WIDTH-1:0] i_v,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_g
);
    localparam int KW = $clog2(WIDTH);

    logic             r_busy;
    logic             r_common;
    logic [WIDTH-1:0] r_u;
    logic [WIDTH-1:0] r_v;
    logic [KW-1:0]    r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_u      <= i_u;
            r_v      <= i_v;
            r_k      <= '0;
            r_common <= 1'b1;
        end else if (r_busy) begin
            if (r_common) begin
                // strip shared factors of two first
                if (r_u[0] || r_v[0]) begin
                    r_common <= 1'b0;
                end else begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + 1'b1;
                end
            end else if (r_v != '0) begin
                if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u > r_v) begin
                    r_u <= r_v;
                    r_v <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
        end
    end

    assign o_done = r_busy && !r_common && (r_v == '0);
    assign o_g    = r_u << r_k;
endmodule
`default_nettype wire

// ----- src/rau_div.sv -----
// Restoring divider, one quotient bit per cycle, WIDTH steps.
`timescale 1ns / 1ps
`default_nettype none
module rau_div #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_n,
    input  wire logic [WIDTH-1:0] i_d,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_q
);
    localparam int CW = $clog2(WIDTH + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH:0]   r_rem;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_d;
    logic [WIDTH:0]   rem_sh;

    assign rem_sh = {r_rem[WIDTH-1:0], r_q[WIDTH-1]};
    assign o_done = r_busy && (r_cnt == CW'(WIDTH));
    assign o_q    = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_q   <= i_n;
            r_d   <= i_d;
        end else if (r_busy && !o_done) begin
            r_cnt <= r_cnt + 1'b1;
            if (rem_sh >= {1'b0, r_d}) begin
                r_rem <= rem_sh - {1'b0, r_d};
                r_q   <= {r_q[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[WIDTH-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: sequencer over shared multiplier, gcd and divider.
//
// Input channel i_in carries an operation code and two fractions a and b; output
// channel o_out carries the reduced fraction, compare flags and a status bit.
// Operands are wrapped to WIDTH bits; all products wrap at WIDTH bits.
// One item is worked on at a time: i_in.ready is high only while the sequencer
// is idle. An item runs three products on the shift-add multiplier (each
// shorter when the multiplier operand has few high bits), then a binary gcd,
// then two exact divisions on the restoring divider. Compare, zero
// denominators and unused codes skip the gcd and divisions. The gcd loop and
// the one-bit multiplier and divider set the time an item takes.
// The result sits in an output register until transferred; the next item may be
// taken meanwhile, but its result waits in the final state while the receiver
// stalls. Reset (synchronous, active low) drops any item in progress and any
// result not yet transferred.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arithmetic_unit_macros.svh"
module rational_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rau_in_if.sink     i_in,
    rau_out_if.source  o_out
);
    import rau_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic             r_go;
    t_func            r_func;
    logic [2:0]       r_code;
    logic [WIDTH-1:0] r_an;
    logic [WIDTH-1:0] r_ad;
    logic [WIDTH-1:0] r_bn;
    logic [WIDTH-1:0] r_bd;
    logic [WIDTH-1:0] r_p0;
    logic [WIDTH-1:0] r_p1;
    logic [WIDTH-1:0] r_p2;
    logic             r_neg;
    logic [WIDTH-1:0] r_mn;
    logic [WIDTH-1:0] r_md;
    logic [WIDTH-1:0] r_g;
    logic [WIDTH-1:0] r_qn;

    logic [31:0]      r_s_num;
    logic [30:0]      r_s_den;
    logic             r_s_lt;
    logic             r_s_eq;
    logic             r_s_gt;
    logic             r_s_st;

    logic             r_out_valid;
    logic [31:0]      r_res_num;
    logic [30:0]      r_res_den;
    logic             r_lt;
    logic             r_eq;
    logic             r_gt;
    logic             r_st;

    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic [WIDTH-1:0] mul_p;
    logic             mul_done;
    logic             gcd_done;
    logic [WIDTH-1:0] gcd_g;
    logic [WIDTH-1:0] div_n;
    logic [WIDTH-1:0] div_q;
    logic             div_done;

    logic [WIDTH-1:0] pre_num;
    logic [WIDTH-1:0] pre_den;
    logic [WIDTH-1:0] pre_mn;
    logic [WIDTH-1:0] pre_md;
    logic [WIDTH-1:0] red_num;
    logic             out_load;

    // ---- shared units ----
    rau_mul #(.WIDTH(WIDTH)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go && (r_state == ST_MUL0 || r_state == ST_MUL1 || r_state == ST_MUL2)),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_p    (mul_p)
    );

    rau_gcd #(.WIDTH(WIDTH)) u_gcd (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go && r_state == ST_GCD),
        .i_u    (r_mn),
        .i_v    (r_md),
        .o_done (gcd_done),
        .o_g    (gcd_g)
    );

    rau_div #(.WIDTH(WIDTH)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go && (r_state == ST_DIVN || r_state == ST_DIVD)),
        .i_n    (div_n),
        .i_d    (r_g),
        .o_done (div_done),
        .o_q    (div_q)
    );

    assign div_n = (r_state == ST_DIVD) ? r_md : r_mn;

    // multiplier operand selection per step and operation
    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        case (r_state)
            ST_MUL0: begin
                mul_a = r_an;
                mul_b = (r_func == FUNC_MUL) ? r_bn : r_bd;
            end
            ST_MUL1: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            ST_MUL2: begin
                mul_a = r_ad;
                mul_b = (r_func == FUNC_DIV) ? r_bn : r_bd;
            end
            default: begin
                mul_a = r_an;
                mul_b = r_bd;
            end
        endcase
    end

    // numerator and denominator before reduction
    always_comb begin
        case (r_func)
            FUNC_ADD: pre_num = r_p0 + r_p1;
            FUNC_SUB: pre_num = r_p0 - r_p1;
            FUNC_MUL: pre_num = r_p0;
            FUNC_DIV: pre_num = r_p0;
            FUNC_RED: pre_num = r_an;
            default:  pre_num = r_p0;
        endcase
        pre_den = (r_func == FUNC_RED) ? r_ad : r_p2;
        pre_mn  = pre_num[WIDTH-1] ? (~pre_num + 1'b1) : pre_num;
        pre_md  = pre_den[WIDTH-1] ? (~pre_den + 1'b1) : pre_den;
    end

    assign red_num  = r_neg ? ('0 - r_qn) : r_qn;
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_MUL0;
            ST_MUL0: if (mul_done) n_state = ST_MUL1;
            ST_MUL1: if (mul_done) n_state = ST_MUL2;
            ST_MUL2: if (mul_done) n_state = ST_PREP;
            ST_PREP: begin
                if (r_code > 3'(FUNC_RED) || r_func == FUNC_CMP || pre_den == '0) begin
                    n_state = ST_FIN;
                end else if (pre_mn == '0) begin
                    n_state = ST_DIVN;
                end else begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD:  if (gcd_done) n_state = ST_DIVN;
            ST_DIVN: if (div_done) n_state = ST_DIVD;
            ST_DIVD: if (div_done) n_state = ST_FIN;
            ST_FIN:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    r_code <= i_in.func;
                    r_func <= t_func'(i_in.func);
                    r_an   <= WIDTH'(i_in.a_num);
                    r_ad   <= WIDTH'(i_in.a_den);
                    r_bn   <= WIDTH'(i_in.b_num);
                    r_bd   <= WIDTH'(i_in.b_den);
                end
            end
            ST_MUL0: if (mul_done) r_p0 <= mul_p;
            ST_MUL1: if (mul_done) r_p1 <= mul_p;
            ST_MUL2: if (mul_done) r_p2 <= mul_p;
            ST_PREP: begin
                r_neg   <= pre_num[WIDTH-1] ^ pre_den[WIDTH-1];
                r_mn    <= pre_mn;
                r_md    <= pre_md;
                r_g     <= {{(WIDTH-1){1'b0}}, 1'b1};
                r_s_num <= '0;
                r_s_den <= 31'd1;
                r_s_lt  <= (r_func == FUNC_CMP) && ($signed(r_p0) < $signed(r_p1));
                r_s_eq  <= (r_func == FUNC_CMP) && (r_p0 == r_p1);
                r_s_gt  <= (r_func == FUNC_CMP) && ($signed(r_p1) < $signed(r_p0));
                r_s_st  <= (r_code <= 3'(FUNC_RED)) && (r_func != FUNC_CMP)
                           && (pre_den == '0);
            end
            ST_GCD:  if (gcd_done) r_g <= gcd_g;
            ST_DIVN: if (div_done) r_qn <= div_q;
            ST_DIVD: begin
                if (div_done) begin
                    // reduced denominator of 2^(WIDTH-1) cannot be represented
                    if (div_q[WIDTH-1]) begin
                        r_s_num <= '0;
                        r_s_den <= 31'd1;
                        r_s_st  <= 1'b1;
                    end else begin
                        r_s_num <= 32'(signed'(red_num));
                        r_s_den <= 31'(div_q);
                        r_s_st  <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res_num <= r_s_num;
            r_res_den <= r_s_den;
            r_lt      <= r_s_lt;
            r_eq      <= r_s_eq;
            r_gt      <= r_s_gt;
            r_st      <= r_s_st;
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.res_num    = r_res_num;
    assign o_out.res_den    = r_res_den;
    assign o_out.is_less    = r_lt;
    assign o_out.is_equal   = r_eq;
    assign o_out.is_greater = r_gt;
    assign o_out.status     = r_st;

    // ---- checks ----
    `RAU_ASSERT_IMPL(a_err_zero_one, i_clk, i_rst_n, o_out.valid && o_out.status,
        o_out.res_num == 32'd0 && o_out.res_den == 31'd1, "error result is not 0/1")
    `RAU_ASSERT_IMPL(a_cmp_zero_one, i_clk, i_rst_n,
        o_out.valid && (o_out.is_less || o_out.is_equal || o_out.is_greater),
        o_out.res_num == 32'd0 && o_out.res_den == 31'd1 && !o_out.status,
        "compare result carries a fraction or error")
    `RAU_ASSERT_IMPL(a_gcd_nonzero, i_clk, i_rst_n, r_state == ST_GCD && gcd_done,
        gcd_g != '0, "gcd finished with zero")
    `RAU_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, out_load,
        o_out.valid && r_state == ST_IDLE, "result load did not present a result")
endmodule
`default_nettype wire

// ----- test/tb_rational_arithmetic_unit.sv -----
// Testbench for the rational arithmetic unit: random and directed fractions, checked per field.
`timescale 1ns / 1ps
`default_nettype none
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    localparam int WIDTH     = 32;
    localparam int MAX_QUIET = 20000;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } t_operands;

    typedef struct packed {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic        is_less;
        logic        is_equal;
        logic        is_greater;
        logic        status;
    } t_fraction_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rau_in_if  in_ch();
    rau_out_if out_ch();

    rational_arithmetic_unit #(.WIDTH(WIDTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    t_operands        pending_ops[$];
    t_fraction_result expected_fracs[$];
    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;
    bit  stim_done = 1'b0;

    function automatic logic [63:0] gcd_mag(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_fraction_result reduce_frac(logic signed [31:0] num,
                                                     logic signed [31:0] den);
        t_fraction_result r;
        logic [63:0] mn, md, g;
        logic        neg;
        logic [31:0] rn;
        r = '0;
        r.res_den = 31'd1;
        if (den == 0) begin
            r.status = 1'b1;
            return r;
        end
        neg = num[31] ^ den[31];
        mn = num[31] ? 64'(-num) & 64'hFFFF_FFFF : 64'(num) & 64'hFFFF_FFFF;
        md = den[31] ? 64'(-den) & 64'hFFFF_FFFF : 64'(den) & 64'hFFFF_FFFF;
        g = (mn == 0) ? 64'd1 : gcd_mag(mn, md);
        mn = mn / g;
        md = md / g;
        if (md >= 64'h8000_0000) begin
            r.status = 1'b1;
            return r;
        end
        rn = neg ? -mn[31:0] : mn[31:0];
        r.res_num = rn;
        r.res_den = md[30:0];
        return r;
    endfunction

    function automatic t_fraction_result fraction_op(t_operands op);
        t_fraction_result r;
        logic signed [31:0] x, y, dd;
        x  = $signed(op.a_num) * $signed(op.b_den);
        y  = $signed(op.b_num) * $signed(op.a_den);
        dd = $signed(op.a_den) * $signed(op.b_den);
        r = '0;
        r.res_den = 31'd1;
        case (op.func)
            FUNC_ADD: r = reduce_frac(x + y, dd);
            FUNC_SUB: r = reduce_frac(x - y, dd);
            FUNC_MUL: r = reduce_frac($signed(op.a_num) * $signed(op.b_num), dd);
            FUNC_DIV: r = reduce_frac(x, $signed(op.a_den) * $signed(op.b_num));
            FUNC_CMP: begin
                r.is_less    = x < y;
                r.is_equal   = x == y;
                r.is_greater = x > y;
            end
            FUNC_RED: r = reduce_frac(op.a_num, op.a_den);
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return -32'($urandom_range(1, 20));
            4, 5, 6: return 32'($urandom_range(1, 60));
            7: return $signed(32'($urandom_range(0, 2000))) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
                {in_ch.func, in_ch.a_num, in_ch.a_den, in_ch.b_num, in_ch.b_den}
                    <= pending_ops[0];
                expected_fracs.push_back(fraction_op(pending_ops.pop_front()));
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_fraction_result got, want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || $urandom_range(0, 99) >= 10;
            quiet_cycles <= ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                            ? 0 : quiet_cycles + 1;
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.res_num, out_ch.res_den, out_ch.is_less, out_ch.is_equal,
                       out_ch.is_greater, out_ch.status};
                if (expected_fracs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_fracs.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: num %h/%h den %h/%h ",
                                      "lt%b/%b eq%b/%b gt%b/%b st%b/%b"},
                                     want.res_num, got.res_num, want.res_den, got.res_den,
                                     want.is_less, got.is_less, want.is_equal, got.is_equal,
                                     want.is_greater, got.is_greater, want.status, got.status);
                    end
                end
            end
            if (quiet_cycles >= MAX_QUIET) begin
                $display("rational_arithmetic_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_operands op;
        logic [31:0] edge_vals[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.a_num = '0;
        in_ch.a_den = '0;
        in_ch.b_num = '0;
        in_ch.b_den = '0;
        out_ch.ready = 1'b0;
        // directed: every code with plain values, then the corner cases
        for (int f = 0; f < 8; f++) pending_ops.push_back({3'(f), 32'd6, -32'd4, 32'd3, 32'd9});
        pending_ops.push_back({FUNC_RED, 32'd0, -32'd7, 32'd0, 32'd1});
        pending_ops.push_back({FUNC_RED, 32'd5, 32'd0, 32'd0, 32'd1});
        pending_ops.push_back({FUNC_RED, 32'd1, 32'h8000_0000, 32'd0, 32'd1});
        pending_ops.push_back({FUNC_RED, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1});
        pending_ops.push_back({FUNC_RED, 32'h8000_0000, 32'd1, 32'd0, 32'd1});
        pending_ops.push_back({FUNC_DIV, 32'd3, 32'd4, 32'd0, 32'd5});
        pending_ops.push_back({FUNC_CMP, 32'd1, 32'd0, 32'd2, 32'd0});
        pending_ops.push_back({FUNC_CMP, 32'd1, 32'd3, 32'd1, 32'd2});
        for (int k = 0; k < 4; k++)
            pending_ops.push_back({3'(k), edge_vals[k], edge_vals[3 - k],
                                   edge_vals[(k + 1) % 4], edge_vals[(k + 2) % 4]});
        for (int n = 0; n < 800; n++) begin
            op.func  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                    : 3'($urandom_range(0, 5));
            op.a_num = pick_value();
            op.a_den = pick_value();
            op.b_num = pick_value();
            op.b_den = pick_value();
            pending_ops.push_back(op);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // a stretch with no idling in the middle of the run
        wait (pending_ops.size() < 500);
        calm = 1'b1;
        wait (pending_ops.size() < 350);
        calm = 1'b0;
        wait (pending_ops.size() == 0 && expected_fracs.size() == 0);
        repeat (8 * WIDTH + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_fracs.size() == 0)
            $display("rational_arithmetic_unit verification clean");
        else
            $display("rational_arithmetic_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
